@@ rtl/tct_pkg.sv @@
// shared widths, status codes and the 32-bit clip for the trilateration block
// no dependencies
package tct_pkg;

    localparam int COORD_WIDTH = 8;
    localparam int RAD_W       = 8;
    localparam int OUT_W       = 32;

    // line coefficients a, b = 2 * coordinate difference
    localparam int AW    = COORD_WIDTH + 2;
    // squared distance of a centre from the origin
    localparam int PSQW  = 2 * COORD_WIDTH + 1;
    localparam int RSQW  = 2 * RAD_W;
    localparam int SQMAX = (2 * COORD_WIDTH > RSQW + 1) ? 2 * COORD_WIDTH : RSQW + 1;
    localparam int CSW   = SQMAX + 2;
    localparam int DETW  = 2 * AW + 1;
    localparam int NUMW  = CSW + AW + 1;
    localparam int YNW   = AW + OUT_W + 1;

    // shared divider geometry
    localparam int DN      = (NUMW > YNW) ? NUMW : YNW;
    localparam int DD      = DETW;
    localparam int QW      = DN + 1;
    localparam int DIV_LAT = DN + 2;

    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_B1X = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_B2X = 3'd2;
    localparam logic [IDX_W-1:0] REG_B2Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_B3X = 3'd4;
    localparam logic [IDX_W-1:0] REG_B3Y = 3'd5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_FLAT     = 2'd2
    } status_t;

    localparam logic signed [QW-1:0] QMAX = QW'(64'sd2147483647);
    localparam logic signed [QW-1:0] QMIN = QW'(-64'sd2147483648);

    // returns {clipped, value}
    function automatic logic [OUT_W:0] clip32(input logic signed [QW-1:0] q);
        logic [OUT_W:0] res;
        if (q > QMAX)
            res = {1'b1, QMAX[OUT_W-1:0]};
        else if (q < QMIN)
            res = {1'b1, QMIN[OUT_W-1:0]};
        else
            res = {1'b0, q[OUT_W-1:0]};
        return res;
    endfunction

endpackage

@@ rtl/tct_div.sv @@
// pipelined signed divider, one quotient bit per stage, truncates toward zero
// depends on tct_pkg
module tct_div (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [tct_pkg::DN-1:0]      num,
    input  logic signed [tct_pkg::DD-1:0]      den,
    output logic signed [tct_pkg::QW-1:0]      quo
);

    localparam int DN = tct_pkg::DN;
    localparam int DD = tct_pkg::DD;
    localparam int QW = tct_pkg::QW;

    logic [DN-1:0] nq_reg  [0:DN];
    logic [DD-1:0] rem_reg [0:DN];
    logic [DD-1:0] dv_reg  [0:DN];
    logic          neg_reg [0:DN];
    logic signed [QW-1:0] quo_reg;

    // magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]  <= num[DN-1] ? DN'(-num) : DN'(num);
            dv_reg[0]  <= den[DD-1] ? DD'(-den) : DD'(den);
            rem_reg[0] <= '0;
            neg_reg[0] <= num[DN-1] ^ den[DD-1];
        end
    end

    genvar i;
    for (i = 0; i < DN; i++)
    begin : g_stage
        logic [DD:0] trial;
        logic [DD:0] diff;
        logic        fit;

        always_comb
        begin
            trial = {rem_reg[i], nq_reg[i][DN-1]};
            diff  = trial - {1'b0, dv_reg[i]};
            fit   = !diff[DD];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= fit ? diff[DD-1:0] : trial[DD-1:0];
                nq_reg[i+1]  <= {nq_reg[i][DN-2:0], fit};
                dv_reg[i+1]  <= dv_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[DN])
                quo_reg <= -$signed({1'b0, nq_reg[DN]});
            else
                quo_reg <= $signed({1'b0, nq_reg[DN]});
        end
    end

    assign quo = quo_reg;

endmodule

@@ rtl/three_circle_trilateration.sv @@
// dividers: two bit-per-stage dividers of DN + 2 stages each
// throughput: one item per cycle; the whole pipe holds while a result waits untaken
// reset: rst_n asynchronous active low, clears all valid bits and loads the
//   beacon centres (5,5), (10,5), (5,10)
// depends on tct_pkg, tct_div
module three_circle_trilateration (
    input  logic        clk,
    input  logic        rst_n,
    // radius item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // radius_one, radius_two, radius_three
    // position item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pos_x, pos_y
    output logic [2:0]  m_tuser,   // status, saturated
    // beacon centre writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tct_pkg::IDX_W-1:0]         cfg_index,
    input  logic [tct_pkg::COORD_WIDTH-1:0]   cfg_data
);

    localparam int CW      = tct_pkg::COORD_WIDTH;
    localparam int RAD_W   = tct_pkg::RAD_W;
    localparam int AW      = tct_pkg::AW;
    localparam int PSQW    = tct_pkg::PSQW;
    localparam int RSQW    = tct_pkg::RSQW;
    localparam int CSW     = tct_pkg::CSW;
    localparam int DETW    = tct_pkg::DETW;
    localparam int NUMW    = tct_pkg::NUMW;
    localparam int YNW     = tct_pkg::YNW;
    localparam int OUT_W   = tct_pkg::OUT_W;
    localparam int DN      = tct_pkg::DN;
    localparam int DD      = tct_pkg::DD;
    localparam int QW      = tct_pkg::QW;
    localparam int DIV_LAT = tct_pkg::DIV_LAT;

    // what rides beside the x division
    typedef struct packed {
        logic                 parallel;
        logic                 flat;
        logic signed [AW-1:0] ya;
        logic signed [AW-1:0] yb;
        logic signed [CSW-1:0] yc;
    } xside_t;

    // what rides beside the y division
    typedef struct packed {
        logic                    parallel;
        logic                    flat;
        logic                    satx;
        logic signed [OUT_W-1:0] x;
    } yside_t;

    // global advance: the whole pipe moves unless a result is stuck at the output
    logic en;
    assign en        = m_tready || !m_tvalid;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // beacon centre registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0] bx_reg [0:2];
    logic signed [CW-1:0] by_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg[0] <= CW'(5);
            by_reg[0] <= CW'(5);
            bx_reg[1] <= CW'(10);
            by_reg[1] <= CW'(5);
            bx_reg[2] <= CW'(5);
            by_reg[2] <= CW'(10);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tct_pkg::REG_B1X: bx_reg[0] <= cfg_data;
                tct_pkg::REG_B1Y: by_reg[0] <= cfg_data;
                tct_pkg::REG_B2X: bx_reg[1] <= cfg_data;
                tct_pkg::REG_B2Y: by_reg[1] <= cfg_data;
                tct_pkg::REG_B3X: bx_reg[2] <= cfg_data;
                tct_pkg::REG_B3Y: by_reg[2] <= cfg_data;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: squares and line slopes for the pairs (1,2), (2,3), (3,1)
    // ------------------------------------------------------------------
    logic                    v1_reg;
    logic        [RSQW-1:0]  rsq1_reg [0:2];
    logic signed [PSQW-1:0]  psq1_reg [0:2];
    logic signed [AW-1:0]    a1_reg   [0:2];
    logic signed [AW-1:0]    b1_reg   [0:2];

    genvar k;
    for (k = 0; k < 3; k++)
    begin : g_s1
        localparam int J = (k == 2) ? 0 : k + 1;
        logic        [RAD_W-1:0]  rad;
        logic signed [2*CW-1:0]   sx;
        logic signed [2*CW-1:0]   sy;

        always_comb
        begin
            rad = s_tdata[k*RAD_W +: RAD_W];
            sx  = bx_reg[k] * bx_reg[k];
            sy  = by_reg[k] * by_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rsq1_reg[k] <= rad * rad;
                psq1_reg[k] <= PSQW'(sx) + PSQW'(sy);
                a1_reg[k]   <= (AW'(bx_reg[J]) - AW'(bx_reg[k])) <<< 1;
                b1_reg[k]   <= (AW'(by_reg[J]) - AW'(by_reg[k])) <<< 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: right-hand sides, pick the first pair with differing y
    // ------------------------------------------------------------------
    logic                  v2_reg;
    logic signed [CSW-1:0] c2_reg [0:1];
    logic signed [AW-1:0]  a2_reg [0:1];
    logic signed [AW-1:0]  b2_reg [0:1];
    logic signed [AW-1:0]  ya2_reg;
    logic signed [AW-1:0]  yb2_reg;
    logic signed [CSW-1:0] yc2_reg;
    logic                  flat2_reg;

    logic signed [CSW-1:0] c_line [0:2];

    for (k = 0; k < 3; k++)
    begin : g_s2
        localparam int J = (k == 2) ? 0 : k + 1;
        always_comb
        begin
            c_line[k] = CSW'(psq1_reg[J]) - CSW'(psq1_reg[k])
                      - CSW'($signed({1'b0, rsq1_reg[J]}))
                      + CSW'($signed({1'b0, rsq1_reg[k]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg[0] <= c_line[0];
            c2_reg[1] <= c_line[1];
            a2_reg[0] <= a1_reg[0];
            a2_reg[1] <= a1_reg[1];
            b2_reg[0] <= b1_reg[0];
            b2_reg[1] <= b1_reg[1];
            if (b1_reg[0] != '0)
            begin
                ya2_reg   <= a1_reg[0];
                yb2_reg   <= b1_reg[0];
                yc2_reg   <= c_line[0];
                flat2_reg <= 1'b0;
            end
            else if (b1_reg[1] != '0)
            begin
                ya2_reg   <= a1_reg[1];
                yb2_reg   <= b1_reg[1];
                yc2_reg   <= c_line[1];
                flat2_reg <= 1'b0;
            end
            else
            begin
                ya2_reg   <= a1_reg[2];
                yb2_reg   <= b1_reg[2];
                yc2_reg   <= c_line[2];
                flat2_reg <= (b1_reg[2] == '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: Cramer cross products
    // ------------------------------------------------------------------
    logic                         v3_reg;
    logic signed [2*AW-1:0]       m0_reg, m1_reg;
    logic signed [CSW+AW-1:0]     n0_reg, n1_reg;
    logic signed [AW-1:0]         ya3_reg, yb3_reg;
    logic signed [CSW-1:0]        yc3_reg;
    logic                         flat3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg    <= a2_reg[0] * b2_reg[1];
            m1_reg    <= a2_reg[1] * b2_reg[0];
            n0_reg    <= c2_reg[0] * b2_reg[1];
            n1_reg    <= c2_reg[1] * b2_reg[0];
            ya3_reg   <= ya2_reg;
            yb3_reg   <= yb2_reg;
            yc3_reg   <= yc2_reg;
            flat3_reg <= flat2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: determinant and x numerator
    // ------------------------------------------------------------------
    logic                   v4_reg;
    logic signed [DETW-1:0] det4_reg;
    logic signed [NUMW-1:0] num4_reg;
    logic signed [AW-1:0]   ya4_reg, yb4_reg;
    logic signed [CSW-1:0]  yc4_reg;
    logic                   flat4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det4_reg  <= DETW'(m0_reg) - DETW'(m1_reg);
            num4_reg  <= NUMW'(n0_reg) - NUMW'(n1_reg);
            ya4_reg   <= ya3_reg;
            yb4_reg   <= yb3_reg;
            yc4_reg   <= yc3_reg;
            flat4_reg <= flat3_reg;
        end
    end

    // ------------------------------------------------------------------
    // x division and its side line
    // ------------------------------------------------------------------
    logic signed [QW-1:0] qx;
    logic                 xv_reg [0:DIV_LAT-1];
    xside_t               xs_reg [0:DIV_LAT-1];

    tct_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (DN'(num4_reg)),
        .den (DD'(det4_reg)),
        .quo (qx)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_reg[0].parallel <= (det4_reg == '0);
            xs_reg[0].flat     <= flat4_reg;
            xs_reg[0].ya       <= ya4_reg;
            xs_reg[0].yb       <= yb4_reg;
            xs_reg[0].yc       <= yc4_reg;
            for (int i = 1; i < DIV_LAT; i++)
                xs_reg[i] <= xs_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: x with the parallel case and clipping
    // ------------------------------------------------------------------
    logic                    v5_reg;
    logic signed [OUT_W-1:0] x5_reg;
    logic                    satx5_reg;
    xside_t                  s5_reg;
    logic [OUT_W:0]          xclip;

    assign xclip = tct_pkg::clip32(qx);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg <= xs_reg[DIV_LAT-1];
            if (xs_reg[DIV_LAT-1].parallel)
            begin
                x5_reg    <= '1;
                satx5_reg <= 1'b0;
            end
            else
            begin
                x5_reg    <= xclip[OUT_W-1:0];
                satx5_reg <= xclip[OUT_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: a * x
    // ------------------------------------------------------------------
    logic                       v6_reg;
    logic signed [AW+OUT_W-1:0] prod6_reg;
    logic signed [AW-1:0]       yb6_reg;
    logic signed [CSW-1:0]      yc6_reg;
    yside_t                     s6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod6_reg       <= s5_reg.ya * x5_reg;
            yb6_reg         <= s5_reg.yb;
            yc6_reg         <= s5_reg.yc;
            s6_reg.parallel <= s5_reg.parallel;
            s6_reg.flat     <= s5_reg.flat;
            s6_reg.satx     <= satx5_reg;
            s6_reg.x        <= x5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: y numerator c - a * x
    // ------------------------------------------------------------------
    logic                  v7_reg;
    logic signed [YNW-1:0] yn7_reg;
    logic signed [AW-1:0]  yb7_reg;
    yside_t                s7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yn7_reg <= YNW'(yc6_reg) - YNW'(prod6_reg);
            yb7_reg <= yb6_reg;
            s7_reg  <= s6_reg;
        end
    end

    // ------------------------------------------------------------------
    // y division and its side line
    // ------------------------------------------------------------------
    logic signed [QW-1:0] qy;
    logic                 yv_reg [0:DIV_LAT-1];
    yside_t               ys_reg [0:DIV_LAT-1];

    tct_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (DN'(yn7_reg)),
        .den (DD'(yb7_reg)),
        .quo (qy)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ys_reg[0] <= s7_reg;
            for (int i = 1; i < DIV_LAT; i++)
                ys_reg[i] <= ys_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // valid bits of every stage
    // ------------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                xv_reg[i] <= 1'b0;
                yv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            xv_reg[0] <= v4_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                xv_reg[i] <= xv_reg[i-1];
                yv_reg[i] <= yv_reg[i-1];
            end
            v5_reg        <= xv_reg[DIV_LAT-1];
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            yv_reg[0]     <= v7_reg;
            out_valid_reg <= yv_reg[DIV_LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // output register: y clip, status, saturation flag
    // ------------------------------------------------------------------
    logic signed [OUT_W-1:0] out_x_reg;
    logic signed [OUT_W-1:0] out_y_reg;
    tct_pkg::status_t        out_status_reg;
    logic                    out_sat_reg;
    logic [OUT_W:0]          yclip;
    yside_t                  yend;

    assign yclip = tct_pkg::clip32(qy);
    assign yend  = ys_reg[DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg <= yend.x;
            if (yend.flat)
            begin
                out_y_reg      <= '0;
                out_sat_reg    <= yend.satx;
                out_status_reg <= tct_pkg::ST_FLAT;
            end
            else
            begin
                out_y_reg      <= yclip[OUT_W-1:0];
                out_sat_reg    <= yend.satx | yclip[OUT_W];
                out_status_reg <= yend.parallel ? tct_pkg::ST_PARALLEL : tct_pkg::ST_OK;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = {out_sat_reg, out_status_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // all beacon y equal gives y of zero
    a_flat_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status_reg == tct_pkg::ST_FLAT |-> out_y_reg == '0)
        else $error("flat beacons but nonzero y");

    // flat beacons always make the lines parallel, so x must be -1
    a_flat_x: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status_reg == tct_pkg::ST_FLAT |-> out_x_reg == '1)
        else $error("flat beacons but x not -1");

    // parallel lines give x of -1
    a_par_x: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_status_reg == tct_pkg::ST_PARALLEL |-> out_x_reg == '1)
        else $error("parallel lines but x not -1");

endmodule
